// ===== src/stem_pkg.sv =====
// Shared codes, command and status types for the sorted timer queue.
package stem_pkg;

    localparam logic [2:0] MODE_ALLOC    = 3'd0;
    localparam logic [2:0] MODE_FREE     = 3'd1;
    localparam logic [2:0] MODE_INIT     = 3'd2;
    localparam logic [2:0] MODE_ACTIVATE = 3'd3;
    localparam logic [2:0] MODE_CANCEL   = 3'd4;
    localparam logic [2:0] MODE_PROCESS  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_OUT     = 3'd3;
    localparam logic [2:0] ST_FREE    = 3'd4;
    localparam logic [2:0] ST_ACTIVE  = 3'd5;
    localparam logic [2:0] ST_NOINIT  = 3'd6;
    localparam logic [2:0] ST_IGNORED = 3'd7;

    localparam logic [2:0] FLAG_FREE   = 3'h1;
    localparam logic [2:0] FLAG_INIT   = 3'h2;
    localparam logic [2:0] FLAG_ACTIVE = 3'h4;

    localparam int MAX_RESULTS = 32;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_DEC,
        OP_ALLOC,
        OP_ACT_LD,
        OP_INS,
        OP_INS_DONE,
        OP_CAN,
        OP_CAN_DONE,
        OP_PRC_EXP,
        OP_PRC_STOP,
        OP_PRC_TAIL,
        OP_PRC_END
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       dec_imm;
        logic       slot_free;
        logic       act_zero;
        logic       shift;
        logic       k_one;
        logic       k_end;
        logic       expire;
        logic       n_zero;
    } sts_t;

endpackage

// ===== src/stem_ram.sv =====
// Generic simple dual-port RAM with registered read.
module stem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/stem_ctrl.sv =====
// Controller state machine of the sorted timer queue.
module stem_ctrl import stem_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DECODE   = 11'b00000000010,
        S_ALLOC    = 11'b00000000100,
        S_ACT_LD   = 11'b00000001000,
        S_INS      = 11'b00000010000,
        S_INS_DONE = 11'b00000100000,
        S_CAN      = 11'b00001000000,
        S_CAN_DONE = 11'b00010000000,
        S_PRC      = 11'b00100000000,
        S_PRC_TAIL = 11'b01000000000,
        S_PRC_END  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.dec_imm) begin
                    if (sts.slot_free) begin
                        cmd.op     = OP_DEC;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.op = OP_DEC;
                    unique case (sts.mode)
                        MODE_ALLOC:    state_next = S_ALLOC;
                        MODE_ACTIVATE: state_next = S_ACT_LD;
                        MODE_CANCEL:   state_next = S_CAN;
                        default:       state_next = S_PRC;
                    endcase
                end
            end
            S_ALLOC: begin
                if (sts.slot_free) begin
                    cmd.op     = OP_ALLOC;
                    state_next = S_IDLE;
                end
            end
            S_ACT_LD: begin
                cmd.op     = OP_ACT_LD;
                state_next = sts.act_zero ? S_INS_DONE : S_INS;
            end
            S_INS: begin
                if (sts.shift) begin
                    cmd.op = OP_INS;
                    if (sts.k_one) begin
                        state_next = S_INS_DONE;
                    end
                end else begin
                    state_next = S_INS_DONE;
                end
            end
            S_INS_DONE: begin
                if (sts.slot_free) begin
                    cmd.op     = OP_INS_DONE;
                    state_next = S_IDLE;
                end
            end
            S_CAN: begin
                cmd.op = OP_CAN;
                if (sts.k_end) begin
                    state_next = S_CAN_DONE;
                end
            end
            S_CAN_DONE: begin
                if (sts.slot_free) begin
                    cmd.op     = OP_CAN_DONE;
                    state_next = S_IDLE;
                end
            end
            S_PRC: begin
                if (sts.expire) begin
                    if (sts.n_zero || sts.slot_free) begin
                        cmd.op     = OP_PRC_EXP;
                        state_next = sts.k_end ? S_PRC_END : S_PRC;
                    end
                end else if (sts.slot_free) begin
                    cmd.op     = OP_PRC_STOP;
                    state_next = sts.n_zero ? S_IDLE : S_PRC_TAIL;
                end
            end
            S_PRC_TAIL: begin
                cmd.op = OP_PRC_TAIL;
                if (sts.k_end) begin
                    state_next = S_IDLE;
                end
            end
            S_PRC_END: begin
                if (sts.slot_free) begin
                    cmd.op     = OP_PRC_END;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== src/stem_dp.sv =====
// Datapath of the sorted timer queue: flags, free stack, period and list memories, result register.
module stem_dp import stem_pkg::*; #(
    parameter int TIMER_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  in_mode,
    input  logic [4:0]  in_index,
    input  logic [30:0] in_period,
    input  logic [31:0] in_now,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_status,
    output logic [4:0]  out_index,
    output logic        out_last
);
    localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam int LW = 32 + TW;

    logic [2:0]    mode_reg;
    logic [4:0]    idx_reg;
    logic [30:0]   period_reg;
    logic [31:0]   now_reg;
    logic [31:0]   exp_reg;
    logic [CW-1:0] k_reg;
    logic [NW-1:0] n_reg;
    logic          found_reg;
    logic [TW-1:0] pend_reg;
    logic [CW-1:0] free_cnt_reg;
    logic [CW-1:0] act_cnt_reg;
    logic [2:0]    flags_reg [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] written_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [4:0]    out_index_reg;
    logic          out_last_reg;

    logic          stk_we, stk_re, per_we, per_re, lst_we, lst_re;
    logic [TW-1:0] stk_waddr, stk_raddr, per_waddr, per_raddr, lst_waddr, lst_raddr;
    logic [TW-1:0] stk_rdata;
    logic [30:0]   per_rdata;
    logic [LW-1:0] lst_wdata, lst_rdata;

    logic          idx_ok, slot_free, dec_imm, push_ok;
    logic [TW-1:0] idx_a, fcm1_a, pop_t, d_idx;
    logic [31:0]   d_exp;
    logic [2:0]    f, chk, imm_status;
    logic [4:0]    imm_index;
    logic [CW-1:0] km1, kp1, km2, fcm1;
    logic          k_end, expire;
    logic          emit, e_last;
    logic [2:0]    e_status;
    logic [4:0]    e_index;

    assign idx_ok    = 32'(idx_reg) < TIMER_COUNT;
    assign idx_a     = TW'(idx_reg);
    assign f         = idx_ok ? flags_reg[idx_a] : FLAG_FREE;
    assign slot_free = !out_valid_reg || out_ready;
    assign push_ok   = 32'(free_cnt_reg) < TIMER_COUNT;
    assign fcm1      = free_cnt_reg - CW'(1);
    assign fcm1_a    = fcm1[TW-1:0];
    assign pop_t     = written_reg[fcm1_a] ? stk_rdata : fcm1_a;
    assign d_exp     = lst_rdata[LW-1:TW];
    assign d_idx     = lst_rdata[TW-1:0];
    assign km1       = k_reg - CW'(1);
    assign km2       = k_reg - CW'(2);
    assign kp1       = k_reg + CW'(1);
    assign k_end     = (kp1 == act_cnt_reg);
    assign expire    = (n_reg < NW'(MAX_RESULTS)) && (d_exp <= now_reg);

    always_comb begin
        if ((f & FLAG_FREE) != 3'b0) begin
            chk = ST_FREE;
        end else if ((f & FLAG_ACTIVE) != 3'b0) begin
            chk = ST_ACTIVE;
        end else begin
            chk = ST_OK;
        end
    end

    // Results that the decode step can answer at once.
    always_comb begin
        dec_imm    = 1'b1;
        imm_status = ST_OK;
        imm_index  = idx_reg;
        unique case (mode_reg)
            MODE_ALLOC: begin
                dec_imm    = (free_cnt_reg == '0);
                imm_status = ST_OUT;
                imm_index  = 5'd0;
            end
            MODE_FREE, MODE_INIT: begin
                imm_status = chk;
            end
            MODE_ACTIVATE: begin
                dec_imm    = (chk != ST_OK) || ((f & FLAG_INIT) == 3'b0);
                imm_status = (chk != ST_OK) ? chk : ST_NOINIT;
            end
            MODE_CANCEL: begin
                dec_imm    = !(idx_ok && ((f & FLAG_ACTIVE) != 3'b0));
                imm_status = ST_IGNORED;
            end
            MODE_PROCESS: begin
                dec_imm    = (act_cnt_reg == '0);
                imm_status = ST_NONE;
                imm_index  = 5'd0;
            end
            default: begin
                imm_index = 5'd0;
            end
        endcase
    end

    always_comb begin
        sts.mode      = mode_reg;
        sts.dec_imm   = dec_imm;
        sts.slot_free = slot_free;
        sts.act_zero  = (act_cnt_reg == '0);
        sts.shift     = !(exp_reg > d_exp);
        sts.k_one     = (k_reg == CW'(1));
        sts.k_end     = k_end;
        sts.expire    = expire;
        sts.n_zero    = (n_reg == '0);
    end

    // Memory ports and result selection.
    always_comb begin
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = free_cnt_reg[TW-1:0];
        stk_raddr = fcm1_a;
        per_we    = 1'b0;
        per_re    = 1'b0;
        per_waddr = idx_a;
        per_raddr = idx_a;
        lst_we    = 1'b0;
        lst_re    = 1'b0;
        lst_waddr = k_reg[TW-1:0];
        lst_raddr = '0;
        lst_wdata = lst_rdata;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_index   = idx_reg;
        e_last    = 1'b1;
        unique case (cmd.op)
            OP_DEC: begin
                if (dec_imm) begin
                    emit     = 1'b1;
                    e_status = imm_status;
                    e_index  = imm_index;
                    stk_we   = (mode_reg == MODE_FREE) && (chk == ST_OK) && push_ok;
                    per_we   = (mode_reg == MODE_INIT) && (chk == ST_OK);
                end else begin
                    stk_re = (mode_reg == MODE_ALLOC);
                    per_re = (mode_reg == MODE_ACTIVATE);
                    lst_re = (mode_reg == MODE_CANCEL) || (mode_reg == MODE_PROCESS);
                end
            end
            OP_ALLOC: begin
                emit    = 1'b1;
                e_index = 5'(pop_t);
            end
            OP_ACT_LD: begin
                lst_re    = (act_cnt_reg != '0);
                lst_raddr = TW'(act_cnt_reg - CW'(1));
            end
            OP_INS: begin
                lst_we    = 1'b1;
                lst_re    = (k_reg != CW'(1));
                lst_raddr = km2[TW-1:0];
            end
            OP_INS_DONE: begin
                lst_we    = 1'b1;
                lst_wdata = {exp_reg, idx_a};
                emit      = 1'b1;
            end
            OP_CAN: begin
                lst_we    = found_reg;
                lst_waddr = km1[TW-1:0];
                lst_re    = !k_end;
                lst_raddr = kp1[TW-1:0];
            end
            OP_CAN_DONE: begin
                emit = 1'b1;
            end
            OP_PRC_EXP: begin
                emit      = (n_reg != '0);
                e_status  = ST_EXPIRED;
                e_index   = 5'(pend_reg);
                e_last    = 1'b0;
                lst_re    = !k_end;
                lst_raddr = kp1[TW-1:0];
            end
            OP_PRC_STOP: begin
                emit     = 1'b1;
                e_status = (n_reg == '0) ? ST_NONE : ST_EXPIRED;
                e_index  = (n_reg == '0) ? 5'd0 : 5'(pend_reg);
            end
            OP_PRC_TAIL: begin
                lst_we    = 1'b1;
                lst_waddr = TW'(k_reg - CW'(n_reg));
                lst_re    = !k_end;
                lst_raddr = kp1[TW-1:0];
            end
            OP_PRC_END: begin
                emit     = 1'b1;
                e_status = ST_EXPIRED;
                e_index  = 5'(pend_reg);
            end
            default: begin
            end
        endcase
    end

    // Control state: flags, counts and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
                flags_reg[i] <= FLAG_FREE;
            end
            written_reg   <= '0;
            free_cnt_reg  <= CW'(TIMER_COUNT);
            act_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_DEC: begin
                    if (dec_imm && (chk == ST_OK)) begin
                        if ((mode_reg == MODE_FREE) && push_ok) begin
                            flags_reg[idx_a]                    <= FLAG_FREE;
                            written_reg[free_cnt_reg[TW-1:0]]   <= 1'b1;
                            free_cnt_reg                        <= free_cnt_reg + CW'(1);
                        end else if (mode_reg == MODE_INIT) begin
                            flags_reg[idx_a] <= f | FLAG_INIT;
                        end
                    end
                end
                OP_ALLOC: begin
                    free_cnt_reg     <= fcm1;
                    flags_reg[pop_t] <= flags_reg[pop_t] & ~FLAG_FREE;
                end
                OP_INS_DONE: begin
                    act_cnt_reg      <= act_cnt_reg + CW'(1);
                    flags_reg[idx_a] <= f | FLAG_ACTIVE;
                end
                OP_CAN_DONE: begin
                    act_cnt_reg      <= act_cnt_reg - CW'(1);
                    flags_reg[idx_a] <= f & ~FLAG_ACTIVE;
                end
                OP_PRC_EXP: begin
                    flags_reg[d_idx] <= flags_reg[d_idx] & ~FLAG_ACTIVE;
                end
                OP_PRC_TAIL: begin
                    if (k_end) begin
                        act_cnt_reg <= act_cnt_reg - CW'(n_reg);
                    end
                end
                OP_PRC_END: begin
                    act_cnt_reg <= act_cnt_reg - CW'(n_reg);
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_status_reg <= e_status;
            out_index_reg  <= e_index;
            out_last_reg   <= e_last;
        end
        unique case (cmd.op)
            OP_LATCH: begin
                mode_reg   <= in_mode;
                idx_reg    <= in_index;
                period_reg <= in_period;
                now_reg    <= in_now;
            end
            OP_DEC: begin
                k_reg     <= '0;
                n_reg     <= '0;
                found_reg <= 1'b0;
            end
            OP_ACT_LD: begin
                exp_reg <= now_reg + {1'b0, per_rdata};
                k_reg   <= act_cnt_reg;
            end
            OP_INS: begin
                k_reg <= km1;
            end
            OP_CAN: begin
                found_reg <= found_reg || (d_idx == idx_a);
                k_reg     <= kp1;
            end
            OP_PRC_EXP: begin
                pend_reg <= d_idx;
                n_reg    <= n_reg + NW'(1);
                k_reg    <= kp1;
            end
            OP_PRC_TAIL: begin
                k_reg <= kp1;
            end
            default: begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

    stem_ram #(.WIDTH(TW), .DEPTH(TIMER_COUNT)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (idx_a),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    stem_ram #(.WIDTH(31), .DEPTH(TIMER_COUNT)) u_period_ram (
        .aclk  (aclk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (period_reg),
        .re    (per_re),
        .raddr (per_raddr),
        .rdata (per_rdata)
    );

    stem_ram #(.WIDTH(LW), .DEPTH(TIMER_COUNT)) u_list_ram (
        .aclk  (aclk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (lst_wdata),
        .re    (lst_re),
        .raddr (lst_raddr),
        .rdata (lst_rdata)
    );
endmodule

// ===== src/sorted_timer_event_manager_core.sv =====
// Top level of the sorted timer queue: a pool of one-shot timers in expiry order.
//
//  channel  direction  tuser           tdata                                  tlast
//  s_       in         mode [2:0]      timer_index, period_ticks, now (72 b)  -
//  m_       out        status [2:0]    result_index (8 b)                     last
//
//  Free, initialize and the immediate error answers finish at decode; allocate
//  pops the free stack; activate walks the list entries compared by the insert;
//  cancel and process walk every listed timer through the dual-port list memory
//  (one entry read a cycle, unless a held result stalls the process walk).
//  Reset clears flags, counts and the stack fill marks: no sweep.
//  A result held on m_ stalls the walk only when the next result is due.
module sorted_timer_event_manager_core import stem_pkg::*; #(
    parameter int TIMER_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_index[4:0], period_ticks[35:5], now[67:36], zero
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // result_index[4:0], zero
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);
    cmd_t       cmd;
    sts_t       sts;
    logic [4:0] res_index;

    // Sequence each word: decode, then walk the list when the mode needs it.
    stem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold timer state, the free stack, the sorted list and the result word.
    stem_dp #(.TIMER_COUNT(TIMER_COUNT)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_tuser),
        .in_index   (s_tdata[4:0]),
        .in_period  (s_tdata[35:5]),
        .in_now     (s_tdata[67:36]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_index  (res_index),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, res_index};
endmodule
